>>> rtl/pixel_to_bearing_angles_defines.svh
// ----------------------------------------------------------------------------
// pixel_to_bearing_angles_defines.svh
// Assertion macros shared by the bearing-angle block.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_BEARING_ANGLES_DEFINES_SVH
`define PIXEL_TO_BEARING_ANGLES_DEFINES_SVH
`ifndef ASSERT_OFF
`define PBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define PBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants of the pixel-to-bearing converter.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int VW = 44;
    localparam int ZW = 28;
    localparam int AW = 30;
    localparam int TAB_LEN = 24;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [AW-1:0] wide_ang_t;

    typedef enum logic [1:0] {
        CMD_FWD  = 2'd0,
        CMD_DOWN = 2'd1,
        CMD_SPAN = 2'd2
    } cmd_t;

    localparam logic [1:0] REG_TPP    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [23:0] TPP_RST    = 24'd4096;
    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    localparam wide_ang_t PI_Q24      = 30'sd52707179;
    localparam wide_ang_t HALF_PI_Q24 = 30'sd26353589;
    localparam vec_t      ONE_Q24     = 44'sd16777216;

    localparam ang_t ATAN_TAB [TAB_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } lane_t;

    typedef struct packed {
        cmd_t cmd;
        logic ctr_row;
        logic left;
        logic neg0;
        logic neg1;
    } side_t;

    // one binary step of the leading-one normalization
    function automatic lane_t norm_step(lane_t l, int unsigned k);
        lane_t r;
        r = l;
        if (((l.x | l.y) >> (41 - k)) == '0)
        begin
            r.x = l.x <<< k;
            r.y = l.y <<< k;
        end
        return r;
    endfunction

endpackage

>>> rtl/pba_in_if.sv
// ----------------------------------------------------------------------------
// pba_in_if
// Pixel request channel.
// ----------------------------------------------------------------------------
interface pba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] radius;

    modport source (output valid, command, pos_x, pos_y, radius, input ready);
    modport sink   (input valid, command, pos_x, pos_y, radius, output ready);
endinterface

>>> rtl/pba_out_if.sv
// ----------------------------------------------------------------------------
// pba_out_if
// Bearing result channel.
// ----------------------------------------------------------------------------
interface pba_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic        [14:0] span;

    modport source (output valid, heading, pitch, span, input ready);
    modport sink   (input valid, heading, pitch, span, output ready);
endinterface

>>> rtl/pixel_to_bearing_angles.sv
// ----------------------------------------------------------------------------
// pixel_to_bearing_angles
// Pinhole-camera pixel to heading / pitch / subtended angle converter.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while the output is not stalled and returns
// one bearing beat per pixel, in order. Two lanes of unrolled CORDIC cells
// (one micro-rotation per cell, one cell per stage) carry the two arctangents
// of each item; all stages advance together and hold while a finished result
// waits on the output. Signed Q4.12 radians, saturated; span unsigned Q3.12.
// ----------------------------------------------------------------------------
`include "pixel_to_bearing_angles_defines.svh"

module pixel_to_bearing_angles #(
    parameter int MAX_DIM       = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pba_in_if.sink      pixel,
    pba_out_if.source   bearing,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [23:0] wr_data
);
    import pba_pkg::*;

    logic        en;
    logic [23:0] tpp_reg;
    logic [12:0] width_reg, height_reg;
    lane_t       l0_q [CORDIC_STAGES+1];
    lane_t       l1_q [CORDIC_STAGES+1];
    side_t       side_reg [CORDIC_STAGES+1];
    logic        val_reg [CORDIC_STAGES+1];
    side_t       prep_side;
    logic        prep_valid;

    assign en          = !bearing.valid || bearing.ready;
    assign pixel.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_reg    <= TPP_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TPP:    tpp_reg    <= wr_data;
                REG_WIDTH:  width_reg  <= wr_data[12:0];
                REG_HEIGHT: height_reg <= wr_data[12:0];
                default:    tpp_reg    <= tpp_reg;
            endcase
        end
    end

    pba_prep #(
        .MAX_DIM (MAX_DIM)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pixel.valid),
        .command  (pixel.command),
        .pos_x    (pixel.pos_x),
        .pos_y    (pixel.pos_y),
        .radius   (pixel.radius),
        .tpp      (tpp_reg),
        .width    (width_reg),
        .height   (height_reg),
        .valid    (prep_valid),
        .side     (prep_side),
        .lane0    (l0_q[0]),
        .lane1    (l1_q[0])
    );

    assign side_reg[0] = prep_side;
    assign val_reg[0]  = prep_valid;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        pba_cell #(.STAGE(i)) u_cell0 (
            .clk  (clk),
            .en   (en),
            .din  (l0_q[i]),
            .dout (l0_q[i+1])
        );
        pba_cell #(.STAGE(i)) u_cell1 (
            .clk  (clk),
            .en   (en),
            .din  (l1_q[i]),
            .dout (l1_q[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[i+1] <= val_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    pba_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (val_reg[CORDIC_STAGES]),
        .side     (side_reg[CORDIC_STAGES]),
        .z0       (l0_q[CORDIC_STAGES].z),
        .z1       (l1_q[CORDIC_STAGES].z),
        .valid    (bearing.valid),
        .heading  (bearing.heading),
        .pitch    (bearing.pitch),
        .span     (bearing.span)
    );

    `PBA_ASSERT_IMPL(a_span_only, clk, rst_n, bearing.valid && bearing.span != 15'd0, bearing.heading == 16'sd0 && bearing.pitch == 16'sd0)
    `PBA_ASSERT_IMPL(a_stall_cause, clk, rst_n, !pixel.ready, bearing.valid && !bearing.ready)
    `PBA_ASSERT_NEXT(a_stall_hold, clk, rst_n, bearing.valid && !bearing.ready, bearing.valid)
endmodule

>>> rtl/pba_prep.sv
// ----------------------------------------------------------------------------
// pba_prep
// Centre offsets, tangent scaling and operand normalization for two lanes.
// ----------------------------------------------------------------------------
module pba_prep #(
    parameter int MAX_DIM = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [1:0]       command,
    input  logic [11:0]      pos_x,
    input  logic [11:0]      pos_y,
    input  logic [11:0]      radius,
    input  logic [23:0]      tpp,
    input  logic [12:0]      width,
    input  logic [12:0]      height,
    output logic             valid,
    output pba_pkg::side_t   side,
    output pba_pkg::lane_t   lane0,
    output pba_pkg::lane_t   lane1
);
    import pba_pkg::*;

    localparam logic [12:0] DIM_CAP = (MAX_DIM > 8191) ? 13'd8191 : 13'(MAX_DIM);

    logic [12:0]        wcl, hcl;
    logic [11:0]        cx, cy;
    logic signed [13:0] dx, dxr, dy, op0, op1;
    logic signed [38:0] prod0, prod1;
    lane_t              a0_next, a1_next;
    side_t              sa_next;
    lane_t              a0_reg, a1_reg, b0_reg, b1_reg, c0_reg, c1_reg;
    side_t              sa_reg, sb_reg, sc_reg;
    logic               va_reg, vb_reg, vc_reg;
    lane_t              b0_next, b1_next, c0_next, c1_next;
    side_t              sb_next;

    always_comb
    begin
        wcl   = (width > DIM_CAP) ? DIM_CAP : width;
        hcl   = (height > DIM_CAP) ? DIM_CAP : height;
        cx    = wcl[12:1];
        cy    = hcl[12:1];
        dx    = $signed({2'b00, pos_x}) - $signed({2'b00, cx});
        dxr   = $signed({1'b0, 13'(pos_x) + 13'(radius)}) - $signed({2'b00, cx});
        dy    = $signed({2'b00, pos_y}) - $signed({2'b00, cy});
        op0   = (command == CMD_SPAN) ? dxr : dx;
        op1   = (command == CMD_SPAN) ? dx : dy;
        prod0 = op0 * $signed({1'b0, tpp});
        prod1 = op1 * $signed({1'b0, tpp});

        a1_next.x = ONE_Q24;
        a1_next.y = VW'(prod1);
        a1_next.z = '0;
        a0_next.z = '0;
        if (command == CMD_DOWN)
        begin
            a0_next.x = dy[13] ? -VW'(dy) : VW'(dy);
            a0_next.y = (dy > 0) ? -VW'(dx) : VW'(dx);
        end
        else
        begin
            a0_next.x = ONE_Q24;
            a0_next.y = VW'(prod0);
        end

        sa_next.cmd     = cmd_t'(command);
        sa_next.ctr_row = (dy == '0);
        sa_next.left    = dx[13];
        sa_next.neg0    = 1'b0;
        sa_next.neg1    = 1'b0;
    end

    always_comb
    begin
        sb_next      = sa_reg;
        sb_next.neg0 = a0_reg.y[VW-1];
        sb_next.neg1 = a1_reg.y[VW-1];
        b0_next      = a0_reg;
        b1_next      = a1_reg;
        b0_next.y    = a0_reg.y[VW-1] ? -a0_reg.y : a0_reg.y;
        b1_next.y    = a1_reg.y[VW-1] ? -a1_reg.y : a1_reg.y;
        b0_next      = norm_step(norm_step(norm_step(b0_next, 32), 16), 8);
        b1_next      = norm_step(norm_step(norm_step(b1_next, 32), 16), 8);
        c0_next      = norm_step(norm_step(norm_step(b0_reg, 4), 2), 1);
        c1_next      = norm_step(norm_step(norm_step(b1_reg, 4), 2), 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            sa_reg <= sa_next;
            b0_reg <= b0_next;
            b1_reg <= b1_next;
            sb_reg <= sb_next;
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            sc_reg <= sb_reg;
        end
    end

    assign valid = vc_reg;
    assign side  = sc_reg;
    assign lane0 = c0_reg;
    assign lane1 = c1_reg;
endmodule

>>> rtl/pba_cell.sv
// ----------------------------------------------------------------------------
// pba_cell
// One vectoring CORDIC micro-rotation with its output register.
// ----------------------------------------------------------------------------
module pba_cell #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           en,
    input  pba_pkg::lane_t din,
    output pba_pkg::lane_t dout
);
    import pba_pkg::*;

    lane_t lane_next, lane_reg;

    always_comb
    begin
        lane_next = din;
        if (din.y > 0)
        begin
            lane_next.x = din.x + (din.y >>> STAGE);
            lane_next.y = din.y - (din.x >>> STAGE);
            lane_next.z = din.z + ATAN_TAB[STAGE];
        end
        else if (din.y < 0)
        begin
            lane_next.x = din.x - (din.y >>> STAGE);
            lane_next.y = din.y + (din.x >>> STAGE);
            lane_next.z = din.z - ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign dout = lane_reg;
endmodule

>>> rtl/pba_finish.sv
// ----------------------------------------------------------------------------
// pba_finish
// Mode combine, Q4.12 rounding and saturation, result register.
// ----------------------------------------------------------------------------
module pba_finish (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  pba_pkg::side_t         side,
    input  pba_pkg::ang_t          z0,
    input  pba_pkg::ang_t          z1,
    output logic                   valid,
    output logic signed [15:0]     heading,
    output logic signed [15:0]     pitch,
    output logic        [14:0]     span
);
    import pba_pkg::*;

    wide_ang_t          a0, a1, d, h_next, p_next, s_next;
    wide_ang_t          h_reg, p_reg, s_reg;
    wide_ang_t          hr, pr, sr;
    logic               vd_reg, vo_reg;
    logic signed [15:0] heading_next, pitch_next, heading_reg, pitch_reg;
    logic        [14:0] span_next, span_reg;

    always_comb
    begin
        a0 = side.neg0 ? -AW'(z0) : AW'(z0);
        a1 = side.neg1 ? -AW'(z1) : AW'(z1);
        d  = a0 - a1;
        h_next = '0;
        p_next = '0;
        s_next = '0;
        unique case (side.cmd)
            CMD_FWD:
            begin
                h_next = a0;
                p_next = -a1;
            end
            CMD_DOWN:
            begin
                if (side.ctr_row)
                begin
                    h_next = side.left ? PI_Q24 : '0;
                end
                else
                begin
                    h_next = a0 + (side.left ? PI_Q24 : '0);
                end
                p_next = -a1 - HALF_PI_Q24;
            end
            CMD_SPAN:
            begin
                s_next = d[AW-1] ? -d : d;
            end
            default:
            begin
                h_next = '0;
            end
        endcase
    end

    always_comb
    begin
        hr = (h_reg + AW'(2048)) >>> 12;
        pr = (p_reg + AW'(2048)) >>> 12;
        sr = (s_reg + AW'(2048)) >>> 12;
        if (hr > AW'(32767))
            heading_next = 16'sh7FFF;
        else if (hr < -AW'(32768))
            heading_next = -16'sh8000;
        else
            heading_next = hr[15:0];
        if (pr > AW'(32767))
            pitch_next = 16'sh7FFF;
        else if (pr < -AW'(32768))
            pitch_next = -16'sh8000;
        else
            pitch_next = pr[15:0];
        span_next = (sr > AW'(32767)) ? 15'h7FFF : sr[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= in_valid;
            vo_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg       <= h_next;
            p_reg       <= p_next;
            s_reg       <= s_next;
            heading_reg <= heading_next;
            pitch_reg   <= pitch_next;
            span_reg    <= span_next;
        end
    end

    assign valid   = vo_reg;
    assign heading = heading_reg;
    assign pitch   = pitch_reg;
    assign span    = span_reg;
endmodule

>>> dv/pba_tb_pkg.sv
// ----------------------------------------------------------------------------
// pba_tb_pkg
// Bearing-angle predictor for the pixel-to-bearing testbench: CORDIC arctangent
// in Q.24 radians, rounded to Q4.12, for forward, downward and subtended beats.
// ----------------------------------------------------------------------------
package pba_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int    N_STAGES  = 16;
    localparam int    DIM_LIMIT = 4096;
    localparam longint Q24_ONE  = 64'sd16777216;
    localparam longint Q24_PI   = 64'sd52707179;
    localparam longint Q24_HPI  = 64'sd26353589;
    localparam longint NORM_TOP = 64'sd1 << 40;

    localparam longint ARCTAN [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic [1:0]  command;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] radius;
    } pixel_t;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [15:0] pitch;
        logic        [14:0] span;
    } bearing_t;

    typedef struct {
        logic [23:0] tpp;
        logic [12:0] width;
        logic [12:0] height;
    } optics_t;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint arctan_q24(longint y, longint x);
        bit     neg;
        longint yy;
        longint z;
        longint nx;
        neg = y < 0;
        yy  = neg ? -y : y;
        z   = 0;
        if (x < 0)
            x = -x;
        if (x == 0 && yy == 0)
            return 0;
        while (x < NORM_TOP && yy < NORM_TOP)
        begin
            x  = x <<< 1;
            yy = yy <<< 1;
        end
        for (int i = 0; i < N_STAGES; i++)
        begin
            if (yy == 0)
                break;
            if (yy > 0)
            begin
                nx = x + floor_shr(yy, i);
                yy = yy - floor_shr(x, i);
                z  = z + ARCTAN[i];
            end
            else
            begin
                nx = x - floor_shr(yy, i);
                yy = yy + floor_shr(x, i);
                z  = z - ARCTAN[i];
            end
            x = nx;
        end
        return neg ? -z : z;
    endfunction

    function automatic longint centre_of(logic [12:0] dim);
        longint d;
        d = dim;
        if (d > DIM_LIMIT)
            d = DIM_LIMIT;
        return d >>> 1;
    endfunction

    function automatic longint offset_angle(longint pix, logic [12:0] dim, logic [23:0] tpp);
        longint t;
        t = tpp;
        return arctan_q24((pix - centre_of(dim)) * t, Q24_ONE);
    endfunction

    function automatic longint round_q12(longint z, longint lo, longint hi);
        longint q;
        q = floor_shr(z + 2048, 12);
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q;
    endfunction

    function automatic bearing_t predict_bearing(pixel_t p, optics_t o);
        bearing_t r;
        longint   px;
        longint   py;
        longint   cx;
        longint   cy;
        longint   h;
        longint   d;
        px = p.pos_x;
        py = p.pos_y;
        r.heading = '0;
        r.pitch   = '0;
        r.span    = '0;
        case (p.command)
            CMD_FWD:
            begin
                r.heading = 16'(round_q12(offset_angle(px, o.width, o.tpp), -32768, 32767));
                r.pitch   = 16'(round_q12(-offset_angle(py, o.height, o.tpp), -32768, 32767));
            end
            CMD_DOWN:
            begin
                cx = centre_of(o.width);
                cy = centre_of(o.height);
                if (py == cy)
                    h = (px >= cx) ? 0 : Q24_PI;
                else
                begin
                    if (cy - py < 0)
                        h = arctan_q24(cx - px, py - cy);
                    else
                        h = arctan_q24(px - cx, cy - py);
                    if (px < cx)
                        h = h + Q24_PI;
                end
                r.heading = 16'(round_q12(h, -32768, 32767));
                r.pitch   = 16'(round_q12(-offset_angle(py, o.height, o.tpp) - Q24_HPI,
                                          -32768, 32767));
            end
            CMD_SPAN:
            begin
                d = offset_angle(px + p.radius, o.width, o.tpp) - offset_angle(px, o.width, o.tpp);
                if (d < 0)
                    d = -d;
                r.span = 15'(round_q12(d, 0, 32767));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction
endpackage

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Pixel-to-bearing testbench: directed table then random pixels across several
// optics settings, random gaps on both channels, one long output stall, and
// in-order field-by-field comparison against table values or the predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;
    import pba_tb_pkg::*;

    localparam int LATENCY   = 21;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 90;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [23:0] wr_data;

    pba_in_if  pixel_ch ();
    pba_out_if bearing_ch ();

    pixel_to_bearing_angles u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel_ch.sink),
        .bearing  (bearing_ch.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    typedef struct {
        pixel_t   pix;
        bit       known;
        bearing_t want;
    } row_t;

    optics_t  optics;
    bearing_t pending_bearings[$];
    int       mismatches;
    int       idle_cycles;
    bit       stim_done;
    bit       long_stall;
    bit       stall_used;

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // output side: random ready, one long hold-off, checking
    initial
    begin
        int gap;
        bearing_t want;
        bearing_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall && !stall_used)
            begin
                stall_used = 1'b1;
                bearing_ch.ready <= 1'b0;
                repeat (60) @(negedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                bearing_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            bearing_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!bearing_ch.valid);
            if (pending_bearings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bearing beat h=%0d p=%0d s=%0d",
                             bearing_ch.heading, bearing_ch.pitch, bearing_ch.span);
            end
            else
            begin
                want = pending_bearings.pop_front();
                if (bearing_ch.heading !== want.heading || bearing_ch.pitch !== want.pitch
                    || bearing_ch.span !== want.span)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bearing mismatch: want h=%0d p=%0d s=%0d got h=%0d p=%0d s=%0d",
                                 want.heading, want.pitch, want.span, bearing_ch.heading,
                                 bearing_ch.pitch, bearing_ch.span);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (bearing_ch.valid && bearing_ch.ready)
            || stim_done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_TPP:    optics.tpp    = val;
            REG_WIDTH:  optics.width  = val[12:0];
            REG_HEIGHT: optics.height = val[12:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_optics(logic [23:0] tpp, logic [12:0] w, logic [12:0] h);
        while (pending_bearings.size() != 0)
            @(posedge clk);
        write_reg(REG_TPP, tpp);
        write_reg(REG_WIDTH, {11'd0, w});
        write_reg(REG_HEIGHT, {11'd0, h});
    endtask

    task automatic send_pixel(pixel_t p, bit known, bearing_t want, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.command <= p.command;
        pixel_ch.pos_x   <= p.pos_x;
        pixel_ch.pos_y   <= p.pos_y;
        pixel_ch.radius  <= p.radius;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        pending_bearings.push_back(known ? want : predict_bearing(p, optics));
        @(negedge clk);
    endtask

    function automatic pixel_t rand_pixel(logic [12:0] w, logic [12:0] h);
        pixel_t p;
        p.command = logic'($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        p.pos_x   = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, w));
        p.pos_y   = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, h));
        if ($urandom_range(0, 7) == 0)
            p.pos_y = 12'(h >> 1);
        p.radius  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
        return p;
    endfunction

    function automatic row_t mk_row(logic [1:0] c, int x, int y, int r, bit k,
                                    int hd, int pt, int sp);
        row_t t;
        t.pix.command   = c;
        t.pix.pos_x     = 12'(x);
        t.pix.pos_y     = 12'(y);
        t.pix.radius    = 12'(r);
        t.known         = k;
        t.want.heading  = 16'(hd);
        t.want.pitch    = 16'(pt);
        t.want.span     = 15'(sp);
        return t;
    endfunction

    initial
    begin
        row_t     dir_rows[$];
        bearing_t none;
        pixel_t   p;
        logic [23:0] tpps [5];
        logic [12:0] dims [5];

        none = '{default: '0};
        optics = '{tpp: TPP_RST, width: WIDTH_RST, height: HEIGHT_RST};
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_TPP;
        wr_data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.command = CMD_FWD;
        pixel_ch.pos_x = '0;
        pixel_ch.pos_y = '0;
        pixel_ch.radius = '0;
        mismatches = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        long_stall = 1'b0;
        stall_used = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // image centre at reset settings: exact zeros / -pi/2 / pi
        dir_rows.push_back(mk_row(CMD_FWD, 320, 240, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 320, 240, 0, 1, 0, -6434, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 0, 240, 0, 1, 12868, -6434, 0));
        dir_rows.push_back(mk_row(CMD_SPAN, 320, 240, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(2'd3, 4095, 4095, 4095, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_FWD, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_FWD, 4095, 4095, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 4095, 4095, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 4095, 240, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_DOWN, 319, 100, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_SPAN, 0, 0, 4095, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_SPAN, 4095, 0, 4095, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_SPAN, 2730, 1365, 1365, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].want, 1'b0);

        tpps = '{24'hFFFFFF, 24'd0, 24'd1, 24'd70000, 24'h555555};
        dims = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd1234};
        for (int ph = 0; ph < 5; ph++)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (LATENCY) @(negedge clk);
            set_optics(tpps[ph], dims[ph], dims[4 - ph]);
            if (ph == 2)
            begin
                p = '{CMD_SPAN, 12'd0, 12'hAAA, 12'h555};
                send_pixel(p, 1'b0, none, 1'b0);
                p = '{CMD_FWD, 12'hFFF, 12'd0, 12'hAAA};
                send_pixel(p, 1'b0, none, 1'b0);
            end
            if (ph == 1)
                long_stall = 1'b1;
            for (int n = 0; n < N_RANDOM; n++)
                send_pixel(rand_pixel(optics.width, optics.height), 1'b0, none,
                           (ph == 1) || (n % 30 < 6));
        end
        pixel_ch.valid <= 1'b0;

        while (pending_bearings.size() != 0)
            @(posedge clk);
        stim_done = 1'b1;
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_in_if.sv
rtl/pba_out_if.sv
rtl/pba_prep.sv
rtl/pba_cell.sv
rtl/pba_finish.sv
rtl/pixel_to_bearing_angles.sv
dv/pba_tb_pkg.sv
dv/tb_top.sv
